FILE: rtl/spa_pkg.sv
`timescale 1ns / 1ps
// Shared types for the sparse polynomial adder: term record, result record,
// command codes and the control bundle driven into each term cell.
// No dependencies.
package spa_pkg;

  typedef enum logic [1:0] {
    CMD_APPEND_FIRST  = 2'd0,
    CMD_APPEND_SECOND = 2'd1,
    CMD_RUN           = 2'd2,
    CMD_CLEAR         = 2'd3
  } cmd_e;

  // one stored term, 40 bits
  typedef struct packed {
    logic signed [15:0] coef;
    logic        [7:0]  ex;
    logic        [7:0]  ey;
    logic        [7:0]  ez;
  } term_t;

  // one result item
  typedef struct packed {
    logic signed [16:0] coef;
    logic        [7:0]  ex;
    logic        [7:0]  ey;
    logic        [7:0]  ez;
    logic               last;
    logic               empty;
    logic               ovf;
  } res_t;

  // per-cell controls
  typedef struct packed {
    logic wr_first;   // load first-store entry
    logic wr_second;  // load second-store entry
    logic clr_used;   // clear used mark
    logic mark_en;    // set used mark if this cell is the first match
    logic live;       // second-store entry holds a valid term
  } cell_ctrl_t;

endpackage

FILE: rtl/sparse_polynomial_add.sv
`timescale 1ns / 1ps
// Sparse three-variable polynomial adder, top level.
// Depends on spa_pkg and spa_cell.
//
// Usage:
//   Input channel s_*: one request per command. s_tuser carries the command
//   (append to first store, append to second store, run, clear); s_tdata
//   carries the term for appends. Appends and clears finish in the cycle they
//   are accepted and produce nothing. A full store drops the term and sets a
//   sticky overflow flag, cleared by the clear command and by reset.
//   Output channel m_*: the run command emits the result terms, one request
//   each, with m_tlast on the final one. An all-cancelled sum gives a single
//   zero term flagged empty in m_tuser.
//   Sequence: each first-store term is handled in ST_KEY (key load), then in
//   ST_MATCH (a compare across the row of cells with a first-match chain);
//   the leftover sweep in ST_SECOND then visits one second-store entry per
//   cycle while the receiver keeps up; ST_KEY and ST_SECOND close the two
//   sweeps and ST_FINISH ends the run. s_tready stays low from a run command
//   until the sequencer is back in idle.
//   s_tready is high only between runs. One result is held back so the final
//   one can carry m_tlast; an output register parts the block from the
//   receiver, and a stalled receiver just holds the sequencer.
//   Reset (rst, synchronous) empties both stores, clears the used marks and
//   the overflow flag, and drops any result in flight.
module sparse_polynomial_add #(
  parameter int MAX_TERMS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // coef[15:0], exp_x[23:16], exp_y[31:24], exp_z[39:32]
  input  logic [1:0]  s_tuser,   // cmd[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // sum_coef[16:0], out_exp_x[24:17], out_exp_y[32:25],
                                 // out_exp_z[40:33]
  output logic        m_tlast,   // last_term
  output logic [1:0]  m_tuser    // empty_result[0], overflow_seen[1]
);
  import spa_pkg::*;

  localparam int CNT_W = $clog2(MAX_TERMS + 1);
  localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_KEY    = 5'b00010,
    ST_MATCH  = 5'b00100,
    ST_SECOND = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] first_count, second_count;
  logic [CNT_W-1:0] idx, idx_next;
  logic             overflow_flag;
  term_t            key;
  res_t             pend, out_item;
  logic             pend_valid, out_valid;

  term_t            in_term;
  cmd_e             in_cmd;
  logic             in_fire;
  logic             out_free, can_push, push;
  res_t             push_item;
  res_t             fin_item;
  logic             mark_en, clr_used, key_load;

  cell_ctrl_t         ctrl [MAX_TERMS];
  logic [MAX_TERMS:0] found;
  logic [MAX_TERMS-1:0] match, used;
  term_t              first_terms [MAX_TERMS];
  term_t              second_terms [MAX_TERMS];
  logic signed [15:0] match_coef;
  logic signed [16:0] sum;
  term_t              sec_cur;

  assign in_term.coef = s_tdata[15:0];
  assign in_term.ex   = s_tdata[23:16];
  assign in_term.ey   = s_tdata[31:24];
  assign in_term.ez   = s_tdata[39:32];
  assign in_cmd       = cmd_e'(s_tuser);

  assign s_tready = (state == ST_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;
  assign can_push = !pend_valid || out_free;

  // ---- row of term cells ----
  assign found[0] = 1'b0;
  genvar k;
  generate
    for (k = 0; k < MAX_TERMS; k++) begin : g_cell
      localparam logic [CNT_W-1:0] K = CNT_W'(k);
      assign ctrl[k].wr_first  = in_fire && (in_cmd == CMD_APPEND_FIRST) &&
                                 (first_count == K);
      assign ctrl[k].wr_second = in_fire && (in_cmd == CMD_APPEND_SECOND) &&
                                 (second_count == K);
      assign ctrl[k].clr_used  = clr_used;
      assign ctrl[k].mark_en   = mark_en;
      assign ctrl[k].live      = (K < second_count);

      spa_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (ctrl[k]),
        .wr_term    (in_term),
        .key        (key),
        .found_in   (found[k]),
        .found_out  (found[k+1]),
        .match      (match[k]),
        .first_term (first_terms[k]),
        .second_term(second_terms[k]),
        .used       (used[k])
      );
    end
  endgenerate

  // at most one cell matches, so an OR of gated coefficients selects it
  always_comb begin
    match_coef = '0;
    for (int n = 0; n < MAX_TERMS; n++) begin
      if (match[n]) begin
        match_coef = match_coef | second_terms[n].coef;
      end
    end
  end

  assign sum     = 17'(key.coef) + 17'(match_coef);
  assign sec_cur = second_terms[idx[IDX_W-1:0]];

  // ---- sequencer ----
  always_comb begin
    state_next = state;
    idx_next   = idx;
    push       = 1'b0;
    push_item  = '0;
    mark_en    = 1'b0;
    clr_used   = 1'b0;
    key_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_fire && (in_cmd == CMD_RUN || in_cmd == CMD_CLEAR)) begin
          clr_used = 1'b1;
        end
        if (in_fire && in_cmd == CMD_RUN) begin
          idx_next   = '0;
          state_next = ST_KEY;
        end
      end
      ST_KEY: begin
        if (idx < first_count) begin
          key_load   = 1'b1;
          state_next = ST_MATCH;
        end else begin
          idx_next   = '0;
          state_next = ST_SECOND;
        end
      end
      ST_MATCH: begin
        push_item.coef = found[MAX_TERMS] ? sum : 17'(key.coef);
        push_item.ex   = key.ex;
        push_item.ey   = key.ey;
        push_item.ez   = key.ez;
        push_item.ovf  = overflow_flag;
        if (found[MAX_TERMS] && sum == '0) begin
          mark_en    = 1'b1;
          idx_next   = idx + 1'b1;
          state_next = ST_KEY;
        end else if (can_push) begin
          push       = 1'b1;
          mark_en    = 1'b1;
          idx_next   = idx + 1'b1;
          state_next = ST_KEY;
        end
      end
      ST_SECOND: begin
        push_item.coef = 17'(sec_cur.coef);
        push_item.ex   = sec_cur.ex;
        push_item.ey   = sec_cur.ey;
        push_item.ez   = sec_cur.ez;
        push_item.ovf  = overflow_flag;
        if (idx >= second_count) begin
          state_next = ST_FINISH;
        end else if (used[idx[IDX_W-1:0]]) begin
          idx_next = idx + 1'b1;
        end else if (can_push) begin
          push     = 1'b1;
          idx_next = idx + 1'b1;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
    idx <= idx_next;
    if (key_load) begin
      key <= first_terms[idx[IDX_W-1:0]];
    end
  end

  // store counts and sticky overflow
  always_ff @(posedge clk) begin
    if (rst) begin
      first_count   <= '0;
      second_count  <= '0;
      overflow_flag <= 1'b0;
    end else if (in_fire) begin
      case (in_cmd)
        CMD_APPEND_FIRST: begin
          if (first_count >= CNT_W'(MAX_TERMS)) overflow_flag <= 1'b1;
          else first_count <= first_count + 1'b1;
        end
        CMD_APPEND_SECOND: begin
          if (second_count >= CNT_W'(MAX_TERMS)) overflow_flag <= 1'b1;
          else second_count <= second_count + 1'b1;
        end
        CMD_CLEAR: begin
          first_count   <= '0;
          second_count  <= '0;
          overflow_flag <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // final item of a run: the held-back term, or the empty marker
  always_comb begin
    fin_item = '0;
    if (pend_valid) begin
      fin_item = pend;
    end else begin
      fin_item.empty = 1'b1;
      fin_item.ovf   = overflow_flag;
    end
    fin_item.last = 1'b1;
  end

  // held-back result and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (push) begin
        pend_valid <= 1'b1;
        out_valid  <= pend_valid || (out_valid && !m_tready);
      end else if (state == ST_FINISH && out_free) begin
        pend_valid <= 1'b0;
        out_valid  <= 1'b1;
      end else if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      pend <= push_item;
      if (pend_valid) begin
        out_item <= pend;
      end
    end else if (state == ST_FINISH && out_free) begin
      out_item <= fin_item;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_item.ez, out_item.ey, out_item.ex, out_item.coef};
  assign m_tlast  = out_item.last;
  assign m_tuser  = {out_item.ovf, out_item.empty};

endmodule

FILE: rtl/spa_cell.sv
`timescale 1ns / 1ps
// One term cell: holds entry k of both term stores and the used mark of the
// second-store entry; compares against the broadcast key and passes the
// first-match chain to its neighbor. Depends on spa_pkg.
module spa_cell (
  input  logic               clk,
  input  logic               rst,
  input  spa_pkg::cell_ctrl_t ctrl,
  input  spa_pkg::term_t     wr_term,
  input  spa_pkg::term_t     key,
  input  logic               found_in,
  output logic               found_out,
  output logic               match,
  output spa_pkg::term_t     first_term,
  output spa_pkg::term_t     second_term,
  output logic               used
);
  import spa_pkg::*;

  logic hit;

  always_ff @(posedge clk) begin
    if (ctrl.wr_first) begin
      first_term <= wr_term;
    end
    if (ctrl.wr_second) begin
      second_term <= wr_term;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (ctrl.clr_used) begin
      used <= 1'b0;
    end else if (ctrl.mark_en && match) begin
      used <= 1'b1;
    end
  end

  // used marks do not gate the match: repeated exponents hit the same entry
  assign hit = ctrl.live && (second_term.ex == key.ex) &&
               (second_term.ey == key.ey) && (second_term.ez == key.ez);
  assign match     = hit && !found_in;
  assign found_out = found_in || hit;

endmodule

FILE: tb/spa_checker.sv
`timescale 1ns / 1ps
// Result checker for the sparse polynomial adder: tracks both term stores from
// the accepted requests, predicts every run's output and compares it.
// Depends on spa_pkg.
module spa_checker #(
  parameter int MAX_TERMS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,
  input  logic        m_tlast,
  input  logic [1:0]  m_tuser,
  output int          errors,
  output int          pending
);
  import spa_pkg::*;

  term_t first_store  [MAX_TERMS];
  term_t second_store [MAX_TERMS];
  int    first_n;
  int    second_n;
  logic  overflow_hit;
  res_t  sum_terms [$];   // predicted output terms, oldest first

  function automatic res_t term_result(term_t t, logic signed [16:0] c);
    res_t r;
    r.coef  = c;
    r.ex    = t.ex;
    r.ey    = t.ey;
    r.ez    = t.ez;
    r.last  = 1'b0;
    r.empty = 1'b0;
    r.ovf   = overflow_hit;
    return r;
  endfunction

  always @(posedge clk) begin
    res_t                  got;
    res_t                  want;
    res_t                  run_terms [$];
    term_t                 t_in;
    logic [MAX_TERMS-1:0]  taken;
    logic signed [16:0]    total;
    int                    hit;
    if (rst) begin
      first_n      = 0;
      second_n     = 0;
      overflow_hit = 1'b0;
      sum_terms.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.coef  = m_tdata[16:0];
        got.ex    = m_tdata[24:17];
        got.ey    = m_tdata[32:25];
        got.ez    = m_tdata[40:33];
        got.last  = m_tlast;
        got.empty = m_tuser[0];
        got.ovf   = m_tuser[1];
        if (sum_terms.size() == 0) begin
          errors++;
          $display("%0t: unexpected term: expected none, got coef=%0d x=%0d y=%0d z=%0d",
                   $time, $signed(got.coef), got.ex, got.ey, got.ez);
        end else begin
          want = sum_terms.pop_front();
          if (got !== want) begin
            errors++;
            $display({"%0t: term mismatch: expected coef=%0d x=%0d y=%0d z=%0d last=%0b ",
                      "empty=%0b ovf=%0b, got coef=%0d x=%0d y=%0d z=%0d last=%0b ",
                      "empty=%0b ovf=%0b"},
                     $time, $signed(want.coef), want.ex, want.ey, want.ez, want.last,
                     want.empty, want.ovf, $signed(got.coef), got.ex, got.ey, got.ez,
                     got.last, got.empty, got.ovf);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        t_in.coef = s_tdata[15:0];
        t_in.ex   = s_tdata[23:16];
        t_in.ey   = s_tdata[31:24];
        t_in.ez   = s_tdata[39:32];
        case (cmd_e'(s_tuser))
          CMD_APPEND_FIRST: begin
            if (first_n >= MAX_TERMS) overflow_hit = 1'b1;
            else begin
              first_store[first_n] = t_in;
              first_n++;
            end
          end
          CMD_APPEND_SECOND: begin
            if (second_n >= MAX_TERMS) overflow_hit = 1'b1;
            else begin
              second_store[second_n] = t_in;
              second_n++;
            end
          end
          CMD_CLEAR: begin
            first_n      = 0;
            second_n     = 0;
            overflow_hit = 1'b0;
          end
          CMD_RUN: begin
            taken = '0;
            run_terms.delete();
            for (int i = 0; i < first_n; i++) begin
              // first equal term in the second store, used or not
              hit = -1;
              for (int k = 0; k < second_n && hit < 0; k++)
                if (first_store[i].ex == second_store[k].ex &&
                    first_store[i].ey == second_store[k].ey &&
                    first_store[i].ez == second_store[k].ez)
                  hit = k;
              if (hit < 0)
                run_terms.push_back(term_result(first_store[i],
                                                17'($signed(first_store[i].coef))));
              else begin
                taken[hit] = 1'b1;
                total = 17'($signed(first_store[i].coef)) +
                        17'($signed(second_store[hit].coef));
                if (total != 0) run_terms.push_back(term_result(first_store[i], total));
              end
            end
            for (int k = 0; k < second_n; k++)
              if (!taken[k])
                run_terms.push_back(term_result(second_store[k],
                                                17'($signed(second_store[k].coef))));
            if (run_terms.size() == 0) begin
              want = term_result('0, '0);
              want.empty = 1'b1;
              run_terms.push_back(want);
            end
            foreach (run_terms[n]) begin
              want = run_terms[n];
              want.last = (n == run_terms.size() - 1);
              sum_terms.push_back(want);
            end
          end
        endcase
      end
    end
    pending = sum_terms.size();
  end

endmodule

FILE: tb/sparse_polynomial_add_test.sv
`timescale 1ns / 1ps
// Testbench top for the sparse polynomial adder: clock, reset, command stimulus
// and receiver stalls, with spa_checker watching both channels.
// Depends on spa_pkg, spa_checker and sparse_polynomial_add.
module sparse_polynomial_add_test;
  import spa_pkg::*;

  localparam int MAX_TERMS       = 16;
  localparam int TARGET_REQUESTS = 460;
  localparam int IDLE_PCT        = 34;   // percent of cycles each side sits out
  localparam int CALM_FROM       = 200;  // request window with no idling at all
  localparam int CALM_TO         = 300;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata  = '0;   // coef[15:0], exp_x[23:16], exp_y[31:24], exp_z[39:32]
  logic [1:0]  s_tuser  = '0;   // cmd[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;         // sum_coef[16:0], out_exp_x[24:17], out_exp_y[32:25],
                                // out_exp_z[40:33]
  logic        m_tlast;         // last_term
  logic [1:0]  m_tuser;         // empty_result[0], overflow_seen[1]

  int   errors;
  int   pending;
  int   sent     = 0;
  logic calm     = 1'b0;
  logic [23:0] exp_pool [4];    // shared exponent triples, so terms collide often

  sparse_polynomial_add #(.MAX_TERMS(MAX_TERMS)) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser)
  );

  spa_checker #(.MAX_TERMS(MAX_TERMS)) sum_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser), .errors(errors), .pending(pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // receiver stalls at random, except inside the calm window
  always @(negedge clk) begin
    m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // One request: optional idle gap, then hold valid until the block takes it.
  // Returns just after the accepting edge.
  task automatic send_request(cmd_e cmd, logic [15:0] c = '0,
                              logic [7:0] x = '0, logic [7:0] y = '0, logic [7:0] z = '0);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = cmd;
    s_tdata  = {z, y, x, c};
    sent++;
    calm = (sent >= CALM_FROM && sent < CALM_TO);
    do @(posedge clk); while (!s_tready);
  endtask

  // mostly small stores; now and then past capacity to hit overflow
  function automatic int term_count();
    if ($urandom_range(0, 9) == 0) return $urandom_range(7, 20);
    return $urandom_range(0, 6);
  endfunction

  function automatic logic [23:0] pick_exps();
    if ($urandom_range(0, 9) < 7) return exp_pool[2'($urandom_range(0, 3))];
    return 24'($urandom);
  endfunction

  // clear (usually), fill both stores interleaved, then run once or twice
  task automatic polynomial_pair();
    term_t firsts  [$];
    term_t seconds [$];
    term_t t;
    logic [23:0] e;
    int nf;
    int ns;
    int k;
    int fi = 0;
    int si = 0;
    nf = term_count();
    ns = term_count();
    foreach (exp_pool[p]) exp_pool[p] = 24'($urandom);
    for (int i = 0; i < nf; i++) begin
      e = pick_exps();
      t.coef = 16'($urandom);
      {t.ez, t.ey, t.ex} = e;
      firsts.push_back(t);
    end
    for (int i = 0; i < ns; i++) begin
      if (nf > 0 && $urandom_range(0, 99) < 40) begin
        // partner of a first term, half the time cancelling it
        k = $urandom_range(0, nf - 1);
        t = firsts[k];
        t.coef = $urandom_range(0, 1) ? -firsts[k].coef : 16'($urandom);
      end else begin
        e = pick_exps();
        t.coef = 16'($urandom);
        {t.ez, t.ey, t.ex} = e;
      end
      seconds.push_back(t);
    end
    if ($urandom_range(0, 3) != 0) send_request(CMD_CLEAR);
    while (fi < nf || si < ns) begin
      if (si >= ns || (fi < nf && $urandom_range(0, 1))) begin
        send_request(CMD_APPEND_FIRST, firsts[fi].coef, firsts[fi].ex, firsts[fi].ey,
                     firsts[fi].ez);
        fi++;
      end else begin
        send_request(CMD_APPEND_SECOND, seconds[si].coef, seconds[si].ex, seconds[si].ey,
                     seconds[si].ez);
        si++;
      end
    end
    send_request(CMD_RUN);
    // stores survive a run; the used marks must not
    if ($urandom_range(0, 3) == 0) send_request(CMD_RUN);
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // run with nothing stored: one empty term
    send_request(CMD_RUN);
    // coefficient and exponent extremes; repeated exponents in the first store
    send_request(CMD_APPEND_FIRST, 16'h7FFF, 8'hFF, 8'hFF, 8'hFF);
    send_request(CMD_APPEND_FIRST, 16'h8000, 8'h00, 8'h00, 8'h00);
    send_request(CMD_APPEND_FIRST, 16'd5, 8'd1, 8'd2, 8'd3);
    send_request(CMD_APPEND_FIRST, 16'd7, 8'd1, 8'd2, 8'd3);
    send_request(CMD_APPEND_SECOND, 16'h7FFF, 8'hFF, 8'hFF, 8'hFF);   // largest sum
    send_request(CMD_APPEND_SECOND, 16'h8000, 8'h00, 8'h00, 8'h00);   // smallest sum
    send_request(CMD_APPEND_SECOND, 16'hFFFB, 8'd1, 8'd2, 8'd3);      // cancels the 5
    send_request(CMD_APPEND_SECOND, 16'd100, 8'd9, 8'd9, 8'd9);       // left over
    send_request(CMD_RUN);
    send_request(CMD_RUN);
    send_request(CMD_CLEAR);
    send_request(CMD_RUN);
    // full cancellation gives the empty term too
    send_request(CMD_APPEND_FIRST, 16'd1, 8'd4, 8'd4, 8'd4);
    send_request(CMD_APPEND_SECOND, 16'hFFFF, 8'd4, 8'd4, 8'd4);
    send_request(CMD_RUN);
    send_request(CMD_CLEAR);

    while (sent < TARGET_REQUESTS) begin
      if ($urandom_range(0, 9) == 0)
        send_request(cmd_e'($urandom_range(0, 3)), 16'($urandom), 8'($urandom),
                     8'($urandom), 8'($urandom));
      else
        polynomial_pair();
    end
    @(negedge clk);
    s_tvalid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (150) @(negedge clk);   // catch anything extra the block might emit
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
